// ===== rtl/fnsf_pkg.sv =====
// Package for the nice transform size finder: widths, divider constants,
// control word types and the microcode table. Used by fft_nice_size_finder_core.
package fnsf_pkg;

  // Largest request handled as given is 2**SIZE_BITS.
  localparam int unsigned SIZE_BITS = 24;
  localparam int unsigned REQ_W = 25;
  localparam int unsigned OUT_W = 25;
  // Candidate and cofactor width: holds 2**SIZE_BITS.
  localparam int unsigned CW = SIZE_BITS + 1;
  // Wide enough to compare any request against the limit.
  localparam int unsigned WIDE_W = (CW > REQ_W) ? CW + 1 : REQ_W + 1;
  localparam int unsigned SMALL_LIMIT = 16;
  // Reciprocal shift: exact floor division for CW-bit values by d <= 8.
  localparam int unsigned MUL_K = CW + 3;
  localparam int unsigned PROD_W = CW + MUL_K;
  localparam int unsigned PC_W = 4;

  localparam logic [63:0] ONE_K = 64'd1 << MUL_K;
  localparam logic [63:0] RECIP2 = ONE_K / 64'd2;
  localparam logic [63:0] RECIP3 = (ONE_K + 64'd2) / 64'd3;
  localparam logic [63:0] RECIP5 = (ONE_K + 64'd4) / 64'd5;
  localparam logic [63:0] RECIP7 = (ONE_K + 64'd6) / 64'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT,
    OP_INIT,
    OP_DIV,
    OP_TEST,
    OP_INC,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_SMALL,
    C_DIVIS,
    C_ACCEPT,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    P2,
    P3,
    P5,
    P7
  } prime_e;

  typedef struct packed {
    op_e               op;
    prime_e            prime;
    cond_e             cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] PC_SMALL = 4'd1;
  localparam logic [PC_W-1:0] PC_INIT  = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV2  = 4'd3;
  localparam logic [PC_W-1:0] PC_TST2  = 4'd4;
  localparam logic [PC_W-1:0] PC_DIV3  = 4'd5;
  localparam logic [PC_W-1:0] PC_TST3  = 4'd6;
  localparam logic [PC_W-1:0] PC_DIV5  = 4'd7;
  localparam logic [PC_W-1:0] PC_TST5  = 4'd8;
  localparam logic [PC_W-1:0] PC_DIV7  = 4'd9;
  localparam logic [PC_W-1:0] PC_TST7  = 4'd10;
  localparam logic [PC_W-1:0] PC_CHECK = 4'd11;
  localparam logic [PC_W-1:0] PC_INC   = 4'd12;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd13;
  localparam logic [PC_W-1:0] PC_DONE  = 4'd14;
  localparam logic [PC_W-1:0] PC_LAST  = PC_DONE;

  function automatic logic [2:0] prime_val(prime_e p);
    logic [2:0] v;
    case (p)
      P2:      v = 3'd2;
      P3:      v = 3'd3;
      P5:      v = 3'd5;
      P7:      v = 3'd7;
      default: v = 3'd2;
    endcase
    return v;
  endfunction

  function automatic logic [MUL_K-1:0] recip(prime_e p);
    logic [MUL_K-1:0] v;
    case (p)
      P2:      v = RECIP2[MUL_K-1:0];
      P3:      v = RECIP3[MUL_K-1:0];
      P5:      v = RECIP5[MUL_K-1:0];
      P7:      v = RECIP7[MUL_K-1:0];
      default: v = RECIP2[MUL_K-1:0];
    endcase
    return v;
  endfunction

  // Microcode: jump to target when cond holds, else step on.
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_WAIT:  w = '{OP_WAIT, P2, C_NO_IN,    PC_WAIT};
      PC_SMALL: w = '{OP_NOP,  P2, C_SMALL,    PC_EMIT};
      PC_INIT:  w = '{OP_INIT, P2, C_NEVER,    PC_WAIT};
      PC_DIV2:  w = '{OP_DIV,  P2, C_NEVER,    PC_WAIT};
      PC_TST2:  w = '{OP_TEST, P2, C_DIVIS,    PC_DIV2};
      PC_DIV3:  w = '{OP_DIV,  P3, C_NEVER,    PC_WAIT};
      PC_TST3:  w = '{OP_TEST, P3, C_DIVIS,    PC_DIV3};
      PC_DIV5:  w = '{OP_DIV,  P5, C_NEVER,    PC_WAIT};
      PC_TST5:  w = '{OP_TEST, P5, C_DIVIS,    PC_DIV5};
      PC_DIV7:  w = '{OP_DIV,  P7, C_NEVER,    PC_WAIT};
      PC_TST7:  w = '{OP_TEST, P7, C_DIVIS,    PC_DIV7};
      PC_CHECK: w = '{OP_NOP,  P2, C_ACCEPT,   PC_EMIT};
      PC_INC:   w = '{OP_INC,  P2, C_ALWAYS,   PC_INIT};
      PC_EMIT:  w = '{OP_EMIT, P2, C_OUT_BUSY, PC_EMIT};
      PC_DONE:  w = '{OP_NOP,  P2, C_ALWAYS,   PC_WAIT};
      default:  w = '{OP_NOP,  P2, C_ALWAYS,   PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/fft_nice_size_finder_core.sv =====
// Nice transform size finder, top level: microcode sequencer and datapath.
// Depends on fnsf_pkg (widths, reciprocal constants, microcode table).
//
// Usage
// - Request channel: in_valid_i / in_ready_o carry req_size_i, one beat per
//   request. Requests above 2**SIZE_BITS are saturated to that value.
// - Result channel: out_valid_o / out_ready_i carry nice_size_o, exactly one
//   beat per request, in request order.
// - A request is taken only while the sequencer sits at its wait step, so one
//   request is in work at a time.
// - Sequence: requests up to 16 go from the size check straight to the deliver
//   step. Larger ones pass the size check, then walk even candidates: per
//   candidate, a divide step and a check step for each factor 2, 3, 5, 7
//   stripped and for each prime's last failed try, then the accept check and,
//   if rejected, a step to the next. The loop runs on the shared reciprocal
//   multiplier. After delivery a done step leads back to the wait step.
// - The result sits in an output register: a stalled receiver does not stop
//   the next request being taken and worked on; the sequencer only holds at
//   its deliver step if the earlier result has still not been taken.
// - Reset clears the sequencer and the output valid; no clearing pass.
module fft_nice_size_finder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fnsf_pkg::REQ_W-1:0]  req_size_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fnsf_pkg::OUT_W-1:0]  nice_size_o
);

  localparam int unsigned CW = fnsf_pkg::CW;

  // Sequencer
  logic [fnsf_pkg::PC_W-1:0] pc_q, pc_d;
  fnsf_pkg::ctrl_t           ctrl;

  // Datapath registers
  logic [CW-1:0]             c_q;      // current candidate
  logic [CW-1:0]             r_q;      // cofactor being stripped
  logic [CW-1:0]             q_q;      // quotient from the last divide step
  logic                      small_q;  // request at or below the small limit
  logic [fnsf_pkg::OUT_W-1:0] out_q;
  logic                      out_valid_q;

  // Combinational datapath
  logic [fnsf_pkg::WIDE_W-1:0] req_wide, lim_wide, sat_wide;
  logic [CW-1:0]             req_sat, c_init;
  logic [fnsf_pkg::PROD_W-1:0] prod;
  logic [CW-1:0]             q_d;
  logic [CW+2:0]             qp;
  logic                      in_fire, divis, accept, out_free, jump;

  assign ctrl = fnsf_pkg::ucode(pc_q);

  // Saturate, then round up to even (cannot overflow: the limit is even)
  assign req_wide = fnsf_pkg::WIDE_W'(req_size_i);
  assign lim_wide = fnsf_pkg::WIDE_W'(1) << fnsf_pkg::SIZE_BITS;
  assign sat_wide = (req_wide > lim_wide) ? lim_wide : req_wide;
  assign req_sat  = sat_wide[CW-1:0];
  assign c_init   = req_sat + CW'(req_sat[0]);

  // Floor division by the selected prime through its reciprocal
  assign prod = fnsf_pkg::PROD_W'(r_q) *
                fnsf_pkg::PROD_W'(fnsf_pkg::recip(ctrl.prime));
  assign q_d  = prod[fnsf_pkg::MUL_K +: CW];

  // Exact division check on the registered quotient
  assign qp    = (CW+3)'(q_q) * (CW+3)'(fnsf_pkg::prime_val(ctrl.prime));
  assign divis = (qp == (CW+3)'(r_q)) && (r_q != '0);

  assign accept = (r_q == CW'(1)) || (r_q == CW'(11)) || (r_q == CW'(13));

  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;

  // Next step
  always_comb begin
    case (ctrl.cond)
      fnsf_pkg::C_NEVER:    jump = 1'b0;
      fnsf_pkg::C_ALWAYS:   jump = 1'b1;
      fnsf_pkg::C_NO_IN:    jump = !in_valid_i;
      fnsf_pkg::C_SMALL:    jump = small_q;
      fnsf_pkg::C_DIVIS:    jump = divis;
      fnsf_pkg::C_ACCEPT:   jump = accept;
      fnsf_pkg::C_OUT_BUSY: jump = !out_free;
      default:              jump = 1'b1;
    endcase
    pc_d = jump ? ctrl.target : pc_q + fnsf_pkg::PC_W'(1);
  end

  // Outputs
  always_comb begin
    in_ready_o  = (ctrl.op == fnsf_pkg::OP_WAIT);
    out_valid_o = out_valid_q;
    nice_size_o = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= fnsf_pkg::PC_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (ctrl.op == fnsf_pkg::OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      fnsf_pkg::OP_WAIT: begin
        if (in_fire) begin
          c_q     <= c_init;
          small_q <= (req_sat <= CW'(fnsf_pkg::SMALL_LIMIT));
        end
      end
      fnsf_pkg::OP_INIT: r_q <= c_q;
      fnsf_pkg::OP_DIV:  q_q <= q_d;
      fnsf_pkg::OP_TEST: begin
        if (divis) begin
          r_q <= q_q;
        end
      end
      fnsf_pkg::OP_INC:  c_q <= c_q + CW'(2);
      fnsf_pkg::OP_EMIT: begin
        if (out_free) begin
          out_q <= fnsf_pkg::OUT_W'(c_q);
        end
      end
      default: ;
    endcase
  end

  // Stripping a factor always shrinks the cofactor
  a_strip_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == fnsf_pkg::OP_TEST && divis) |=> (r_q < $past(r_q)))
    else $error("cofactor did not shrink after stripping a factor");

  // Candidates advance by two
  a_inc_by_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == fnsf_pkg::OP_INC) |=> (c_q == $past(c_q) + CW'(2)))
    else $error("candidate did not advance by two");

  // Every delivered size is even
  a_even_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == fnsf_pkg::OP_EMIT && out_free) |=> (out_valid_q && !out_q[0]))
    else $error("odd size delivered");

  // The step counter stays inside the program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= fnsf_pkg::PC_LAST)
    else $error("step counter left the program");

endmodule
